>>> rtl/lsf_pkg.sv
`timescale 1ns / 1ps

package lsf_pkg;

    // Field widths of the point and fit channels.
    localparam int X_W         = 16;
    localparam int Y_W         = 16;
    localparam int SLOPE_W     = 48;
    localparam int ICPT_W      = 48;
    localparam int COUNT_OUT_W = 11;

    // Fraction bits of the Q32.16 results.
    localparam int FRAC_W = 16;

    // Number of finished data sets the queue can hold.
    localparam int Q_DEPTH = 2;

    localparam logic signed [SLOPE_W-1:0] SAT_MAX = {1'b0, {(SLOPE_W - 1){1'b1}}};
    localparam logic signed [SLOPE_W-1:0] SAT_MIN = {1'b1, {(SLOPE_W - 1){1'b0}}};

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL_NSXY,
        BK_MUL_SXSY,
        BK_MUL_NSXX,
        BK_MUL_SXSX,
        BK_CHECK,
        BK_DIV_SLOPE,
        BK_MUL_SLOPE,
        BK_DIV_ICPT,
        BK_OUT
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> rtl/lsf_point_if.sv
`timescale 1ns / 1ps

interface lsf_point_if;
    import lsf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic signed [X_W-1:0] x_value;
    logic signed [Y_W-1:0] y_value;
    logic                  last_point;

    modport source (output valid, output x_value, output y_value, output last_point,
                    input ready);
    modport sink   (input valid, input x_value, input y_value, input last_point,
                    output ready);
endinterface

>>> rtl/lsf_fit_if.sv
`timescale 1ns / 1ps

interface lsf_fit_if;
    import lsf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [ICPT_W-1:0]  intercept;
    logic                      degenerate;
    logic [COUNT_OUT_W-1:0]    point_count;

    modport source (output valid, output slope, output intercept, output degenerate,
                    output point_count, input ready);
    modport sink   (input valid, input slope, input intercept, input degenerate,
                    input point_count, output ready);
endinterface

>>> rtl/lsf_front.sv
`timescale 1ns / 1ps

module lsf_front #(
    parameter int MAX_POINTS = 1024,
    localparam int CW     = $clog2(MAX_POINTS + 1),
    localparam int SXW    = lsf_pkg::X_W + CW,
    localparam int SXYW   = 2 * lsf_pkg::X_W + CW,
    localparam int SNAP_W = CW + 2 * SXW + 2 * SXYW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lsf_point_if.sink         i_point,
    input  lsf_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output logic [SNAP_W-1:0] o_snap
);
    import lsf_pkg::*;

    logic [CW-1:0]            r_count, n_count, w_cnt;
    logic signed [SXW-1:0]    r_sx, n_sx, w_sx;
    logic signed [SXW-1:0]    r_sy, n_sy, w_sy;
    logic signed [SXYW-1:0]   r_sxy, n_sxy, w_sxy;
    logic signed [SXYW-1:0]   r_sxx, n_sxx, w_sxx;
    logic signed [2*X_W-1:0]  w_xy, w_xx;
    logic                     w_accept;
    logic                     w_room;

    assign i_point.ready = !i_q_stat.full;
    assign w_accept      = i_point.valid && i_point.ready;
    assign w_room        = r_count < CW'(MAX_POINTS);
    assign w_xy          = i_point.x_value * i_point.y_value;
    assign w_xx          = i_point.x_value * i_point.x_value;

    // Sums including the offered point; the point is dropped once the set is full.
    always_comb begin
        w_cnt = r_count;
        w_sx  = r_sx;
        w_sy  = r_sy;
        w_sxy = r_sxy;
        w_sxx = r_sxx;
        if (w_room) begin
            w_cnt = r_count + 1'b1;
            w_sx  = r_sx + SXW'(i_point.x_value);
            w_sy  = r_sy + SXW'(i_point.y_value);
            w_sxy = r_sxy + SXYW'(w_xy);
            w_sxx = r_sxx + SXYW'(w_xx);
        end
    end

    always_comb begin
        n_count = r_count;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_sxy   = r_sxy;
        n_sxx   = r_sxx;
        if (w_accept) begin
            if (i_point.last_point) begin
                n_count = '0;
                n_sx    = '0;
                n_sy    = '0;
                n_sxy   = '0;
                n_sxx   = '0;
            end else begin
                n_count = w_cnt;
                n_sx    = w_sx;
                n_sy    = w_sy;
                n_sxy   = w_sxy;
                n_sxx   = w_sxx;
            end
        end
    end

    assign o_push = w_accept && i_point.last_point;
    assign o_snap = {w_cnt, w_sx, w_sy, w_sxy, w_sxx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxy   <= '0;
            r_sxx   <= '0;
        end else begin
            r_count <= n_count;
            r_sx    <= n_sx;
            r_sy    <= n_sy;
            r_sxy   <= n_sxy;
            r_sxx   <= n_sxx;
        end
    end

endmodule

>>> rtl/lsf_queue.sv
`timescale 1ns / 1ps

module lsf_queue #(
    parameter int W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [W-1:0]     i_data,
    input  logic             i_pop,
    output logic [W-1:0]     o_data,
    output lsf_pkg::t_q_stat o_stat
);
    import lsf_pkg::*;

    localparam int DEPTH = Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_stat.full  = r_cnt == CNT_W'(DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign o_data       = r_mem[r_rd];

    assign w_do_push = i_push && !o_stat.full;
    assign w_do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("data set pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("data set popped from an empty queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue fill count out of range");

endmodule

>>> rtl/lsf_mul.sv
`timescale 1ns / 1ps

module lsf_mul #(
    parameter int AW = 27,
    parameter int BW = 48,
    localparam int PW = AW + BW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [PW-1:0] o_prod,
    output logic                 o_done
);
    import lsf_pkg::*;

    localparam int CNT_W = $clog2(AW + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_neg;
    logic [AW-1:0]    r_a;
    logic [PW-1:0]    r_b;
    logic [PW-1:0]    r_acc;
    logic [PW-1:0]    r_prod;
    logic [AW-1:0]    w_a_mag;
    logic [BW-1:0]    w_b_mag;

    assign w_a_mag = $unsigned(i_a[AW-1] ? -i_a : i_a);
    assign w_b_mag = $unsigned(i_b[BW-1] ? -i_b : i_b);

    assign o_prod = $signed(r_prod);
    assign o_done = r_done;

    // Shift-and-add over the bits of the short operand, sign applied at the end.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= w_a_mag;
            r_b   <= PW'(w_b_mag);
            r_acc <= '0;
            r_neg <= i_a[AW-1] ^ i_b[BW-1];
        end else if (r_busy) begin
            if (r_cnt == CNT_W'(AW)) begin
                r_prod <= r_neg ? -r_acc : r_acc;
            end else begin
                if (r_a[0]) begin
                    r_acc <= r_acc + r_b;
                end
                r_b <= r_b << 1;
                r_a <= r_a >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(AW)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/lsf_div.sv
`timescale 1ns / 1ps

module lsf_div #(
    parameter int DW = 91,
    parameter int VW = 74
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dvd,
    input  logic [VW-1:0] i_dvs,
    output logic [DW-1:0] o_quo,
    output logic          o_done
);
    import lsf_pkg::*;

    localparam int CNT_W = $clog2(DW);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DW-1:0]    r_q;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_dvs;
    logic [VW:0]      w_trial;
    logic [VW:0]      w_diff;
    logic             w_ge;

    // Restoring division, one quotient bit per cycle; the dividend shifts out
    // of r_q while the quotient shifts in behind it.
    assign w_trial = {r_rem, r_q[DW-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    assign o_quo  = r_q;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
            r_q   <= {r_q[DW-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/lsf_back.sv
`timescale 1ns / 1ps

module lsf_back #(
    parameter int MAX_POINTS = 1024,
    localparam int CW     = $clog2(MAX_POINTS + 1),
    localparam int SXW    = lsf_pkg::X_W + CW,
    localparam int SXYW   = 2 * lsf_pkg::X_W + CW,
    localparam int SNAP_W = CW + 2 * SXW + 2 * SXYW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsf_pkg::t_q_stat  i_q_stat,
    input  logic [SNAP_W-1:0] i_q_data,
    output logic              o_q_pop,
    lsf_fit_if.source         o_fit
);
    import lsf_pkg::*;

    localparam int BW = (SXYW > SLOPE_W) ? SXYW : SLOPE_W;
    localparam int PW = SXW + BW;
    localparam int DW = PW + FRAC_W;
    localparam int VW = PW - 1;

    t_back_state r_state, n_state;
    logic        r_go, n_go;

    logic [CW-1:0]          w_q_n;
    logic signed [SXW-1:0]  w_q_sx, w_q_sy;
    logic signed [SXYW-1:0] w_q_sxy, w_q_sxx;

    logic [CW-1:0]               r_n;
    logic signed [SXW-1:0]       r_sx, r_sy;
    logic signed [SXYW-1:0]      r_sxy, r_sxx;
    logic signed [PW-1:0]        r_num, r_den;
    logic signed [PW:0]          r_inum;
    logic signed [SLOPE_W-1:0]   r_slope;
    logic signed [ICPT_W-1:0]    r_icpt;
    logic                        r_degen;

    logic                        r_out_valid;
    logic signed [SLOPE_W-1:0]   r_out_slope;
    logic signed [ICPT_W-1:0]    r_out_icpt;
    logic                        r_out_degen;
    logic [COUNT_OUT_W-1:0]      r_out_count;

    logic                 w_mul_start, w_mul_done;
    logic signed [SXW-1:0] w_mul_a;
    logic signed [BW-1:0] w_mul_b;
    logic signed [PW-1:0] w_prod;
    logic                 w_div_start, w_div_done;
    logic [DW-1:0]        w_div_dvd;
    logic [VW-1:0]        w_div_dvs;
    logic [DW-1:0]        w_quo;
    logic [PW-1:0]        w_num_mag;
    logic [PW:0]          w_inum_mag;
    logic                 w_degen;
    logic                 w_out_load;

    function automatic logic signed [SLOPE_W-1:0] f_sat(input logic i_neg,
                                                       input logic [DW-1:0] i_q);
        logic               hi;
        logic [SLOPE_W-1:0] low;
        hi  = |i_q[DW-1:SLOPE_W];
        low = i_q[SLOPE_W-1:0];
        if (i_neg) begin
            if (hi || (low[SLOPE_W-1] && |low[SLOPE_W-2:0])) begin
                f_sat = SAT_MIN;
            end else begin
                f_sat = $signed(-low);
            end
        end else begin
            if (hi || low[SLOPE_W-1]) begin
                f_sat = SAT_MAX;
            end else begin
                f_sat = $signed(low);
            end
        end
    endfunction

    assign {w_q_n, w_q_sx, w_q_sy, w_q_sxy, w_q_sxx} = i_q_data;

    assign w_num_mag  = $unsigned(r_num[PW-1] ? -r_num : r_num);
    assign w_inum_mag = $unsigned(r_inum[PW] ? -r_inum : r_inum);
    assign w_degen    = r_den[PW-1] || (r_den == '0) || (r_n == '0);

    lsf_mul #(.AW(SXW), .BW(BW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_prod  (w_prod),
        .o_done  (w_mul_done)
    );

    lsf_div #(.DW(DW), .VW(VW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_dvd   (w_div_dvd),
        .i_dvs   (w_div_dvs),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:      if (!i_q_stat.empty) n_state = BK_MUL_NSXY;
            BK_MUL_NSXY:  if (w_mul_done) n_state = BK_MUL_SXSY;
            BK_MUL_SXSY:  if (w_mul_done) n_state = BK_MUL_NSXX;
            BK_MUL_NSXX:  if (w_mul_done) n_state = BK_MUL_SXSX;
            BK_MUL_SXSX:  if (w_mul_done) n_state = BK_CHECK;
            BK_CHECK:     n_state = w_degen ? BK_OUT : BK_DIV_SLOPE;
            BK_DIV_SLOPE: if (w_div_done) n_state = BK_MUL_SLOPE;
            BK_MUL_SLOPE: if (w_mul_done) n_state = BK_DIV_ICPT;
            BK_DIV_ICPT:  if (w_div_done) n_state = BK_OUT;
            BK_OUT:       if (!r_out_valid || o_fit.ready) n_state = BK_IDLE;
            default:      n_state = BK_IDLE;
        endcase
        n_go = (n_state != r_state) &&
               (n_state inside {BK_MUL_NSXY, BK_MUL_SXSY, BK_MUL_NSXX, BK_MUL_SXSX,
                                BK_DIV_SLOPE, BK_MUL_SLOPE, BK_DIV_ICPT});
    end

    // Unit operands and handshakes per state.
    always_comb begin
        o_q_pop     = 1'b0;
        w_out_load  = 1'b0;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_mul_a     = r_sx;
        w_mul_b     = '0;
        w_div_dvd   = {w_num_mag, {FRAC_W{1'b0}}};
        w_div_dvs   = r_den[VW-1:0];
        case (r_state)
            BK_IDLE: begin
                o_q_pop = !i_q_stat.empty;
            end
            BK_MUL_NSXY: begin
                w_mul_start = r_go;
                w_mul_a     = SXW'($signed({1'b0, r_n}));
                w_mul_b     = BW'(r_sxy);
            end
            BK_MUL_SXSY: begin
                w_mul_start = r_go;
                w_mul_b     = BW'(r_sy);
            end
            BK_MUL_NSXX: begin
                w_mul_start = r_go;
                w_mul_a     = SXW'($signed({1'b0, r_n}));
                w_mul_b     = BW'(r_sxx);
            end
            BK_MUL_SXSX: begin
                w_mul_start = r_go;
                w_mul_b     = BW'(r_sx);
            end
            BK_DIV_SLOPE: begin
                w_div_start = r_go;
            end
            BK_MUL_SLOPE: begin
                w_mul_start = r_go;
                w_mul_b     = BW'(r_slope);
            end
            BK_DIV_ICPT: begin
                w_div_start = r_go;
                w_div_dvd   = DW'(w_inum_mag);
                w_div_dvs   = VW'(r_n);
            end
            BK_OUT: begin
                w_out_load = !r_out_valid || o_fit.ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_n   <= w_q_n;
            r_sx  <= w_q_sx;
            r_sy  <= w_q_sy;
            r_sxy <= w_q_sxy;
            r_sxx <= w_q_sxx;
        end
        case (r_state)
            BK_MUL_NSXY:  if (w_mul_done) r_num <= w_prod;
            BK_MUL_SXSY:  if (w_mul_done) r_num <= r_num - w_prod;
            BK_MUL_NSXX:  if (w_mul_done) r_den <= w_prod;
            BK_MUL_SXSX:  if (w_mul_done) r_den <= r_den - w_prod;
            BK_CHECK: begin
                r_degen <= w_degen;
                if (w_degen) begin
                    r_slope <= '0;
                    r_icpt  <= '0;
                end
            end
            BK_DIV_SLOPE: if (w_div_done) r_slope <= f_sat(r_num[PW-1], w_quo);
            BK_MUL_SLOPE: begin
                if (w_mul_done) begin
                    r_inum <= ((PW + 1)'(r_sy) <<< FRAC_W) - (PW + 1)'(w_prod);
                end
            end
            BK_DIV_ICPT:  if (w_div_done) r_icpt <= f_sat(r_inum[PW], w_quo);
            default: ;
        endcase
        if (w_out_load) begin
            r_out_slope <= r_slope;
            r_out_icpt  <= r_icpt;
            r_out_degen <= r_degen;
            r_out_count <= COUNT_OUT_W'(r_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_fit.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_fit.valid       = r_out_valid;
    assign o_fit.slope       = r_out_slope;
    assign o_fit.intercept   = r_out_icpt;
    assign o_fit.degenerate  = r_out_degen;
    assign o_fit.point_count = r_out_count;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_degen) |-> (r_out_slope == '0 && r_out_icpt == '0))
        else $error("degenerate fit carries a nonzero slope or intercept");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == BK_MUL_NSXY || r_state == BK_MUL_SXSY ||
                        r_state == BK_MUL_NSXX || r_state == BK_MUL_SXSX ||
                        r_state == BK_MUL_SLOPE))
        else $error("multiplier finished outside a multiply step");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == BK_DIV_SLOPE || r_state == BK_DIV_ICPT))
        else $error("divider finished outside a divide step");

endmodule

>>> rtl/least_squares_line_fit.sv
`timescale 1ns / 1ps

// Channel   Dir  Transfer when          Payload
// i_point   in   valid && ready         x_value, y_value, last_point
// o_fit     out  valid && ready         slope, intercept, degenerate, point_count
//
// Points are taken one per cycle while the queue is not full; the running sums update
// in the cycle of the transfer. A point marked last pushes its data set into a two-entry
// queue and clears the sums. The back end works through the queued data sets one at a
// time, using a bit-serial multiplier and divider.
// i_point stalls only while the queue is full; o_fit stalls hold only the back end.
// Reset is synchronous and active low; it clears the sums, queue and sequencer.

module least_squares_line_fit #(
    parameter int MAX_POINTS = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsf_point_if.sink i_point,
    lsf_fit_if.source o_fit
);
    import lsf_pkg::*;

    // Accumulator widths follow from the largest data set:
    // count needs CW bits, sums of x and y SXW, sums of x*y and x*x SXYW.
    localparam int CW     = $clog2(MAX_POINTS + 1);
    localparam int SXW    = X_W + CW;
    localparam int SXYW   = 2 * X_W + CW;
    localparam int SNAP_W = CW + 2 * SXW + 2 * SXYW;

    logic              w_push;
    logic              w_pop;
    logic [SNAP_W-1:0] w_snap_in;
    logic [SNAP_W-1:0] w_snap_out;
    t_q_stat           w_q_stat;

    // Front end: accumulates points and hands each finished data set to the queue.
    lsf_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_point  (i_point),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_snap   (w_snap_in)
    );

    // The queue lets the front end keep taking points while a fit is in progress.
    lsf_queue #(.W(SNAP_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_snap_in),
        .i_pop   (w_pop),
        .o_data  (w_snap_out),
        .o_stat  (w_q_stat)
    );

    // Back end: forms numerator and denominator, divides, saturates and
    // holds the result in an output register until the sink takes it.
    lsf_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_q_data (w_snap_out),
        .o_q_pop  (w_pop),
        .o_fit    (o_fit)
    );

endmodule
